// ----- src/rxrb_pkg.sv -----
`default_nettype none

package rxrb_pkg;

   localparam int CHAR_W  = 7;
   localparam int BYTE_W  = 8;
   localparam int FREE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int OP_W    = 2;
   localparam int CSR_A_W = 2;

   localparam logic [CHAR_W-1:0] RESET_CHAR_RST  = 7'd24;
   localparam logic [CHAR_W-1:0] STATUS_CHAR_RST = 7'd63;
   localparam logic [CHAR_W-1:0] START_CHAR_RST  = 7'd126;
   localparam logic [CHAR_W-1:0] HOLD_CHAR_RST   = 7'd33;

   typedef enum logic [OP_W-1:0] {
      OP_RECV  = 2'd0,
      OP_READ  = 2'd1,
      OP_FLUSH = 2'd2,
      OP_IDLE  = 2'd3
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      EV_NONE   = 3'd0,
      EV_RESET  = 3'd1,
      EV_STATUS = 3'd2,
      EV_START  = 3'd3,
      EV_HOLD   = 3'd4,
      EV_EXT    = 3'd5
   } event_kind_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_RESET_CHAR  = 2'd0,
      CSR_STATUS_CHAR = 2'd1,
      CSR_START_CHAR  = 2'd2,
      CSR_HOLD_CHAR   = 2'd3
   } csr_index_type;

   // strobes from the controller to the slot memory
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctrl_type;

endpackage

`default_nettype wire

// ----- src/rxrb_if.sv -----
`default_nettype none

interface rxrb_req_if import rxrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output opcode, output byte_in, input ready);
   modport sink   (input valid, input opcode, input byte_in, output ready);
endinterface

interface rxrb_rsp_if import rxrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_byte;
   logic              read_empty;
   logic [FREE_W-1:0] free_count;
   logic [KIND_W-1:0] event_kind;
   logic [BYTE_W-1:0] event_byte;
   logic              dropped_full;

   modport source (output valid, output read_byte, output read_empty, output free_count,
                   output event_kind, output event_byte, output dropped_full, input ready);
   modport sink   (input valid, input read_byte, input read_empty, input free_count,
                   input event_kind, input event_byte, input dropped_full, output ready);
endinterface

`default_nettype wire

// ----- src/rxrb_store.sv -----
`default_nettype none

module rxrb_store
   import rxrb_pkg::*;
#(
   parameter int SLOTS = 129,
   parameter int IDX_W = 8
) (
   input  wire logic              clock,
   input  wire mem_ctrl_type      mem_ctrl,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output      logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_ff [SLOTS];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctrl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/rxrb_ctrl.sv -----
`default_nettype none

module rxrb_ctrl
   import rxrb_pkg::*;
#(
   parameter int CAPACITY = 128,
   parameter int SLOTS    = 129,
   parameter int IDX_W    = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   rxrb_req_if.sink                 req_ch,
   rxrb_rsp_if.source               rsp_ch,
   input  wire logic                csr_we,
   input  wire logic [CSR_A_W-1:0]  csr_index,
   input  wire logic [CHAR_W-1:0]   csr_wdata,
   output      mem_ctrl_type        mem_ctrl,
   output      logic [IDX_W-1:0]    wr_addr,
   output      logic [BYTE_W-1:0]   wr_data,
   output      logic [IDX_W-1:0]    rd_addr,
   input  wire logic [BYTE_W-1:0]   rd_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0] CAP_IDX  = IDX_W'(CAPACITY);

   logic [CHAR_W-1:0] reset_char_ff, status_char_ff, start_char_ff, hold_char_ff;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic              rsp_valid_ff;
   logic              read_hit_ff, read_hit_in;
   logic              read_empty_ff, read_empty_in;
   logic [FREE_W-1:0] free_ff, free_in;
   event_kind_type    kind_ff, kind_in;
   logic [BYTE_W-1:0] event_byte_ff, event_byte_in;
   logic              dropped_ff, dropped_in;

   logic              accept;
   opcode_type        op;
   logic [IDX_W-1:0]  wr_next, rd_next;
   logic              full;
   logic              do_write, do_read;
   logic [IDX_W-1:0]  free_idx;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign op           = opcode_type'(req_ch.opcode);

   assign wr_next = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
   assign rd_next = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
   assign full    = (wr_next == rd_idx_ff);

   // classify, then move the pointers
   always_comb begin
      kind_in       = EV_NONE;
      event_byte_in = '0;
      dropped_in    = 1'b0;
      read_hit_in   = 1'b0;
      read_empty_in = 1'b0;
      do_write      = 1'b0;
      do_read       = 1'b0;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      case (op)
         OP_RECV: begin
            if (req_ch.byte_in == {1'b0, reset_char_ff}) begin
               kind_in = EV_RESET;
            end else if (req_ch.byte_in == {1'b0, status_char_ff}) begin
               kind_in = EV_STATUS;
            end else if (req_ch.byte_in == {1'b0, start_char_ff}) begin
               kind_in = EV_START;
            end else if (req_ch.byte_in == {1'b0, hold_char_ff}) begin
               kind_in = EV_HOLD;
            end else if (req_ch.byte_in[BYTE_W-1]) begin
               kind_in = EV_EXT;
            end
            if (kind_in != EV_NONE) begin
               event_byte_in = req_ch.byte_in;
            end else if (full) begin
               dropped_in = 1'b1;
            end else begin
               do_write  = 1'b1;
               wr_idx_in = wr_next;
            end
         end
         OP_READ: begin
            if (wr_idx_ff == rd_idx_ff) begin
               read_empty_in = 1'b1;
            end else begin
               read_hit_in = 1'b1;
               do_read     = 1'b1;
               rd_idx_in   = rd_next;
            end
         end
         OP_FLUSH: begin
            rd_idx_in = wr_idx_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (wr_idx_in >= rd_idx_in) begin
         free_idx = CAP_IDX - (wr_idx_in - rd_idx_in);
      end else begin
         free_idx = rd_idx_in - wr_idx_in - 1'b1;
      end
      free_in = FREE_W'(free_idx);
   end

   assign mem_ctrl.wr_en = accept && do_write;
   assign mem_ctrl.rd_en = accept && do_read;
   assign wr_addr        = wr_idx_ff;
   assign wr_data        = req_ch.byte_in;
   assign rd_addr        = rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_char_ff  <= RESET_CHAR_RST;
         status_char_ff <= STATUS_CHAR_RST;
         start_char_ff  <= START_CHAR_RST;
         hold_char_ff   <= HOLD_CHAR_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RESET_CHAR:  reset_char_ff  <= csr_wdata;
            CSR_STATUS_CHAR: status_char_ff <= csr_wdata;
            CSR_START_CHAR:  start_char_ff  <= csr_wdata;
            CSR_HOLD_CHAR:   hold_char_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            wr_idx_ff    <= wr_idx_in;
            rd_idx_ff    <= rd_idx_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_hit_ff   <= read_hit_in;
         read_empty_ff <= read_empty_in;
         free_ff       <= free_in;
         kind_ff       <= kind_in;
         event_byte_ff <= event_byte_in;
         dropped_ff    <= dropped_in;
      end
   end

   // popped byte arrives from the memory's read register
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.read_byte    = read_hit_ff ? rd_data : '0;
   assign rsp_ch.read_empty   = read_empty_ff;
   assign rsp_ch.free_count   = free_ff;
   assign rsp_ch.event_kind   = kind_ff;
   assign rsp_ch.event_byte   = event_byte_ff;
   assign rsp_ch.dropped_full = dropped_ff;

endmodule

`default_nettype wire

// ----- src/rx_ring_buffer_realtime_filter.sv -----
// The response to an accepted request is registered and held in the output register.
// Throughput: one request per cycle; each request makes at most one slot write or read.
// A request is taken whenever the output register is empty or being emptied.
// Reset (synchronous): pointers to zero, buffer empty, realtime characters to defaults.
// Slot memory contents are not cleared; only written slots are ever read.
`default_nettype none

module rx_ring_buffer_realtime_filter
   import rxrb_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   rxrb_req_if.sink                req_ch,
   rxrb_rsp_if.source              rsp_ch,
   input  wire logic               csr_we,
   input  wire logic [CSR_A_W-1:0] csr_index,
   input  wire logic [CHAR_W-1:0]  csr_wdata
);

   localparam int SLOTS = CAPACITY + 1;
   localparam int IDX_W = $clog2(SLOTS);

   mem_ctrl_type      mem_ctrl;
   logic [IDX_W-1:0]  wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [BYTE_W-1:0] rd_data;

   rxrb_ctrl #(
      .CAPACITY (CAPACITY),
      .SLOTS    (SLOTS),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mem_ctrl  (mem_ctrl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   rxrb_store #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock    (clock),
      .mem_ctrl (mem_ctrl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

endmodule

`default_nettype wire

// ----- src/rxrb_checker.sv -----
`default_nettype none

module rxrb_checker
   import rxrb_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] read_byte,
   input wire logic              read_empty,
   input wire logic [FREE_W-1:0] free_count,
   input wire logic [KIND_W-1:0] event_kind,
   input wire logic [BYTE_W-1:0] event_byte,
   input wire logic              dropped_full
);

   // an empty read carries nothing else
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && read_empty |-> read_byte == '0 && event_kind == EV_NONE && !dropped_full)
      else $error("empty read with other fields set");

   // a drop only happens when no slot is free
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped_full |-> free_count == '0 && event_kind == EV_NONE)
      else $error("byte dropped while slots free");

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> free_count <= FREE_W'(CAPACITY))
      else $error("free count above capacity");

   a_event_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (event_kind == EV_NONE && event_byte == '0)
                 || (event_kind == EV_EXT && event_byte[BYTE_W-1])
                 || (event_kind != EV_NONE && event_kind != EV_EXT && !event_byte[BYTE_W-1]))
      else $error("event byte does not fit event kind");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(free_count)
                                  && $stable(event_kind) && $stable(event_byte))
      else $error("stalled response changed");

endmodule

bind rx_ring_buffer_realtime_filter rxrb_checker #(
   .CAPACITY (CAPACITY)
) u_rxrb_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .read_byte    (rsp_ch.read_byte),
   .read_empty   (rsp_ch.read_empty),
   .free_count   (rsp_ch.free_count),
   .event_kind   (rsp_ch.event_kind),
   .event_byte   (rsp_ch.event_byte),
   .dropped_full (rsp_ch.dropped_full)
);

`default_nettype wire

// ----- tb/rxrb_fifo_checker.sv -----
module rxrb_fifo_checker
   import rxrb_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   rxrb_req_if                     req_mon,
   rxrb_rsp_if                     rsp_mon,
   input  wire logic               csr_we,
   input  wire logic [CSR_A_W-1:0] csr_index,
   input  wire logic [CHAR_W-1:0]  csr_wdata,
   output int                      mismatch_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              read_empty;
      logic [FREE_W-1:0] free_count;
      event_kind_type    event_kind;
      logic [BYTE_W-1:0] event_byte;
      logic              dropped_full;
   } fifo_rsp_type;

   logic [BYTE_W-1:0] slot_mem [0:CAPACITY];
   logic [7:0]        head_idx;
   logic [7:0]        tail_idx;
   logic [CHAR_W-1:0] rt_char [4];
   fifo_rsp_type      pending_responses [$];

   function automatic logic [7:0] ring_advance(input logic [7:0] idx);
      return (idx == CAPACITY) ? 8'd0 : idx + 8'd1;
   endfunction

   function automatic logic [FREE_W-1:0] free_slots(input logic [7:0] head,
                                                    input logic [7:0] tail);
      if (head >= tail)
         return FREE_W'(CAPACITY - (head - tail));
      return tail - head - 8'd1;
   endfunction

   task automatic predict_fifo_response(input opcode_type op, input logic [BYTE_W-1:0] b,
                                        output fifo_rsp_type r);
      logic [7:0] nxt;
      r = '0;
      case (op)
         OP_RECV: begin
            // first match wins: reset, status, start, hold
            if (b == {1'b0, rt_char[CSR_RESET_CHAR]})       r.event_kind = EV_RESET;
            else if (b == {1'b0, rt_char[CSR_STATUS_CHAR]}) r.event_kind = EV_STATUS;
            else if (b == {1'b0, rt_char[CSR_START_CHAR]})  r.event_kind = EV_START;
            else if (b == {1'b0, rt_char[CSR_HOLD_CHAR]})   r.event_kind = EV_HOLD;
            else if (b[BYTE_W-1])                           r.event_kind = EV_EXT;
            if (r.event_kind != EV_NONE) begin
               r.event_byte = b;
            end else begin
               nxt = ring_advance(head_idx);
               if (nxt != tail_idx) begin
                  slot_mem[head_idx] = b;
                  head_idx = nxt;
               end else begin
                  r.dropped_full = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (head_idx == tail_idx) begin
               r.read_empty = 1'b1;
            end else begin
               r.read_byte = slot_mem[tail_idx];
               tail_idx = ring_advance(tail_idx);
            end
         end
         OP_FLUSH: begin
            tail_idx = head_idx;
         end
         default: ;
      endcase
      r.free_count = free_slots(head_idx, tail_idx);
   endtask

   task automatic compare_response(input fifo_rsp_type exp, input fifo_rsp_type act);
      if (act.read_byte !== exp.read_byte || act.read_empty !== exp.read_empty ||
          act.free_count !== exp.free_count || act.event_kind !== exp.event_kind ||
          act.event_byte !== exp.event_byte || act.dropped_full !== exp.dropped_full) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display({"%0t mismatch: read_byte %h/%h empty %b/%b free %0d/%0d",
                      " kind %0d/%0d ev %h/%h drop %b/%b (exp/act)"},
                     $time, exp.read_byte, act.read_byte, exp.read_empty, act.read_empty,
                     exp.free_count, act.free_count, exp.event_kind, act.event_kind,
                     exp.event_byte, act.event_byte, exp.dropped_full, act.dropped_full);
      end
   endtask

   always @(posedge clock) begin
      fifo_rsp_type act;
      fifo_rsp_type pred;
      if (reset) begin
         head_idx = '0;
         tail_idx = '0;
         rt_char[CSR_RESET_CHAR]  = RESET_CHAR_RST;
         rt_char[CSR_STATUS_CHAR] = STATUS_CHAR_RST;
         rt_char[CSR_START_CHAR]  = START_CHAR_RST;
         rt_char[CSR_HOLD_CHAR]   = HOLD_CHAR_RST;
         pending_responses.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            act.read_byte    = rsp_mon.read_byte;
            act.read_empty   = rsp_mon.read_empty;
            act.free_count   = rsp_mon.free_count;
            act.event_kind   = event_kind_type'(rsp_mon.event_kind);
            act.event_byte   = rsp_mon.event_byte;
            act.dropped_full = rsp_mon.dropped_full;
            if (pending_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t mismatch: response with no request outstanding", $time);
            end else begin
               compare_response(pending_responses.pop_front(), act);
            end
         end
         if (csr_we)
            rt_char[csr_index] = csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            predict_fifo_response(opcode_type'(req_mon.opcode), req_mon.byte_in, pred);
            pending_responses.push_back(pred);
         end
      end
      pending_count = pending_responses.size();
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rxrb_pkg::*;

   localparam int CAPACITY    = 128;
   localparam int PHASE_ITEMS = 235;
   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we;
   logic [CSR_A_W-1:0] csr_index;
   logic [CHAR_W-1:0]  csr_wdata;
   int                 cycle_count = 0;
   int                 items_sent = 0;
   int                 mismatch_count;
   int                 pending_count;
   logic [CHAR_W-1:0]  rt_char [4];

   always #1 clock = ~clock;

   rxrb_req_if req_ch ();
   rxrb_rsp_if rsp_ch ();

   rx_ring_buffer_realtime_filter #(.CAPACITY(CAPACITY)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rxrb_fifo_checker #(.CAPACITY(CAPACITY)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // no idling on either side while calm_window() holds
   function automatic bit calm_window();
      return (cycle_count % 3000) >= 2300;
   endfunction

   always @(negedge clock) begin
      rsp_ch.ready <= calm_window() || ($urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rx_ring_buffer_realtime_filter regression: fail");
         $finish;
      end
   end

   // called and returning at a falling edge; drop valid once the request is taken
   task automatic send_request(input opcode_type op, input logic [BYTE_W-1:0] b);
      while (!calm_window() && $urandom_range(99) < 15) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.opcode  = op;
      req_ch.byte_in = b;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   function automatic bit is_rt_char(input logic [BYTE_W-1:0] b);
      return b == {1'b0, rt_char[0]} || b == {1'b0, rt_char[1]} ||
             b == {1'b0, rt_char[2]} || b == {1'b0, rt_char[3]};
   endfunction

   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(127)); while (is_rt_char(b));
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] stream_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return BYTE_W'($urandom_range(127));
      if (pick < 75) return {1'b0, rt_char[2'($urandom_range(3))]};
      if (pick < 92) return BYTE_W'($urandom_range(255, 128));
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [BYTE_W-1:0] any_byte();
      return BYTE_W'($urandom_range(255));
   endfunction

   task automatic wait_until_drained();
      while (pending_count != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_realtime_chars(input logic [CHAR_W-1:0] c_reset,
                                       input logic [CHAR_W-1:0] c_status,
                                       input logic [CHAR_W-1:0] c_start,
                                       input logic [CHAR_W-1:0] c_hold);
      wait_until_drained();
      csr_we = 1'b1;
      csr_index = CSR_RESET_CHAR;  csr_wdata = c_reset;  @(negedge clock);
      csr_index = CSR_STATUS_CHAR; csr_wdata = c_status; @(negedge clock);
      csr_index = CSR_START_CHAR;  csr_wdata = c_start;  @(negedge clock);
      csr_index = CSR_HOLD_CHAR;   csr_wdata = c_hold;   @(negedge clock);
      csr_we = 1'b0;
      rt_char[CSR_RESET_CHAR]  = c_reset;
      rt_char[CSR_STATUS_CHAR] = c_status;
      rt_char[CSR_START_CHAR]  = c_start;
      rt_char[CSR_HOLD_CHAR]   = c_hold;
   endtask

   task automatic run_random_phase(input int budget);
      int stop_at;
      int burst_len;
      int pick;
      stop_at = items_sent + budget;
      // empty, then overfill with plain bytes so the full drop is hit every phase
      send_request(OP_FLUSH, any_byte());
      repeat (CAPACITY + 3) send_request(OP_RECV, plain_byte());
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         burst_len = $urandom_range(40, 1);
         if (pick < 35) begin
            repeat (burst_len) send_request(OP_RECV, stream_byte());
         end else if (pick < 60) begin
            repeat (burst_len) send_request(OP_READ, any_byte());
         end else begin
            repeat (burst_len) begin
               pick = $urandom_range(99);
               if (pick < 50)      send_request(OP_RECV, stream_byte());
               else if (pick < 82) send_request(OP_READ, any_byte());
               else if (pick < 91) send_request(OP_FLUSH, any_byte());
               else                send_request(OP_IDLE, any_byte());
            end
         end
      end
   endtask

   initial begin
      csr_we         = 1'b0;
      csr_index      = CSR_RESET_CHAR;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.opcode  = OP_RECV;
      req_ch.byte_in = '0;
      rsp_ch.ready   = 1'b0;
      rt_char[CSR_RESET_CHAR]  = RESET_CHAR_RST;
      rt_char[CSR_STATUS_CHAR] = STATUS_CHAR_RST;
      rt_char[CSR_START_CHAR]  = START_CHAR_RST;
      rt_char[CSR_HOLD_CHAR]   = HOLD_CHAR_RST;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: store bounds, each realtime character, extended bytes, empty read
      send_request(OP_RECV, 8'h00);
      send_request(OP_RECV, 8'h7F);
      send_request(OP_RECV, {1'b0, RESET_CHAR_RST});
      send_request(OP_RECV, {1'b0, STATUS_CHAR_RST});
      send_request(OP_RECV, {1'b0, START_CHAR_RST});
      send_request(OP_RECV, {1'b0, HOLD_CHAR_RST});
      send_request(OP_RECV, 8'h80);
      send_request(OP_RECV, 8'hFF);
      send_request(OP_RECV, 8'h2A);
      send_request(OP_READ, 8'h00);
      send_request(OP_READ, 8'hFF);
      send_request(OP_READ, 8'h00);
      send_request(OP_READ, 8'h00);
      send_request(OP_RECV, 8'h55);
      send_request(OP_FLUSH, 8'h00);
      send_request(OP_READ, 8'h00);
      send_request(OP_IDLE, 8'hFF);
      send_request(OP_RECV, 8'h01);
      send_request(OP_IDLE, 8'h00);
      send_request(OP_READ, 8'h00);

      // duplicated characters exercise the match priority
      write_realtime_chars('0, '0, '0, '0);
      run_random_phase(PHASE_ITEMS);
      write_realtime_chars('1, '1, '1, '1);
      run_random_phase(PHASE_ITEMS);
      write_realtime_chars(7'd0, 7'd127, 7'd1, 7'd126);
      run_random_phase(PHASE_ITEMS);
      write_realtime_chars(7'd5, 7'd5, 7'd9, 7'd9);
      run_random_phase(PHASE_ITEMS);
      repeat (2) begin
         write_realtime_chars(CHAR_W'($urandom_range(127)), CHAR_W'($urandom_range(127)),
                              CHAR_W'($urandom_range(127)), CHAR_W'($urandom_range(127)));
         run_random_phase(PHASE_ITEMS);
      end

      req_ch.valid = 1'b0;
      wait_until_drained();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("rx_ring_buffer_realtime_filter regression: pass");
      else
         $display("rx_ring_buffer_realtime_filter regression: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
src/rxrb_pkg.sv
src/rxrb_if.sv
src/rxrb_store.sv
src/rxrb_ctrl.sv
src/rx_ring_buffer_realtime_filter.sv
src/rxrb_checker.sv
tb/rxrb_fifo_checker.sv
tb/tb_top.sv
